// ----- sv/byte_shuffle_xor_cipher_macros.svh -----
// Assertion macros for the byte shuffle XOR cipher (clock i_clk, reset i_rst_n)
`ifndef BYTE_SHUFFLE_XOR_CIPHER_MACROS_SVH
`define BYTE_SHUFFLE_XOR_CIPHER_MACROS_SVH

// Same-cycle implication
`define BSX_CHECK(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define BSX_CHECK_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/bsx_pkg.sv -----
// Shared types, constants and functions of the byte shuffle XOR cipher
`timescale 1ns / 1ps
`default_nettype none

package bsx_pkg;

    // Default message buffer depth in bytes
    localparam int BUFFER_BYTES_DEF = 64;
    localparam int KEY_BYTES        = 16;

    // Result status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_BAD_PAD  = 2'd1;
    localparam logic [1:0] ST_SHORT    = 2'd2;
    localparam logic [1:0] ST_OVERFLOW = 2'd3;

    // Configuration register indexes
    localparam logic REG_KEY_LOW  = 1'b0;
    localparam logic REG_KEY_HIGH = 1'b1;

    // Fixed IV mixed into the configured key
    localparam logic [7:0] CIPHER_IV [KEY_BYTES] = '{
        8'he0, 8'h20, 8'h3a, 8'h08, 8'h49, 8'h06, 8'h24, 8'h5c,
        8'hc2, 8'h29, 8'hac, 8'h12, 8'h91, 8'h95, 8'he4, 8'h79
    };

    // Sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_EVAL,
        S_ENC_RD,
        S_ENC_OUT,
        S_SCAN_RD,
        S_SCAN_CHK,
        S_DEC_RD,
        S_DEC_OUT
    } t_state;

    // Padding marker byte (pad - 1) from the low three bits of the length
    function automatic logic [7:0] pad_marker(input logic [2:0] len_low);
        logic [7:0] mark;
        if (len_low == 3'd7) begin
            mark = 8'd8;
        end else begin
            mark = 8'd7 - {5'd0, len_low};
        end
        return mark;
    endfunction

    // Effective key byte: configured byte XOR IV
    function automatic logic [7:0] key_byte(input logic [127:0] key, input logic [3:0] idx);
        return key[{idx, 3'b000} +: 8] ^ CIPHER_IV[idx];
    endfunction

endpackage

`default_nettype wire

// ----- sv/bsx_store.sv -----
// Message byte store: one write port, one registered read port
`timescale 1ns / 1ps
`default_nettype none

module bsx_store #(
    parameter int  DEPTH = bsx_pkg::BUFFER_BYTES_DEF,
    localparam int AW    = $clog2(DEPTH)
) (
    input  wire logic          i_clk,
    input  wire logic          i_wr_en,
    input  wire logic [AW-1:0] i_wr_addr,
    input  wire logic [7:0]    i_wr_data,
    input  wire logic [AW-1:0] i_rd_addr,
    output logic      [7:0]    o_rd_data
);

    logic [7:0] r_mem [DEPTH];
    logic [7:0] r_rd_data;

    // Write and registered read
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

// ----- sv/bsx_xform.sv -----
// Shared byte transform: position to source address, then key/pad mixing
`timescale 1ns / 1ps
`default_nettype none

module bsx_xform #(
    parameter int  BUFFER_BYTES = bsx_pkg::BUFFER_BYTES_DEF,
    localparam int AW           = $clog2(BUFFER_BYTES),
    localparam int CW           = $clog2(BUFFER_BYTES + 1),
    localparam int RW           = CW - 2
) (
    input  wire logic          i_decrypt,
    input  wire logic [AW-1:0] i_pos,
    input  wire logic [RW-1:0] i_rows,
    input  wire logic [CW-1:0] i_count,
    input  wire logic [127:0]  i_key,
    input  wire logic [7:0]    i_rd_data,
    output logic      [AW-1:0] o_rd_addr,
    output logic      [7:0]    o_value
);

    logic [AW-3:0] row;
    logic [1:0]    col;
    logic [RW-1:0] row_w;
    logic [RW-1:0] nrow;
    logic [1:0]    ncol;
    logic          tail;
    logic [AW-1:0] src;
    logic [7:0]    plain;

    assign row   = i_pos[AW-1:2];
    assign col   = i_pos[1:0];
    assign row_w = RW'(row);

    // Decrypt bytes past the last full row are only XORed
    assign tail = i_decrypt && (CW'(i_pos) >= {i_rows, 2'b00});

    // Row and column rotation: forward for encrypt, inverse for decrypt
    always_comb begin
        if (i_decrypt) begin
            nrow = (row_w == '0) ? (i_rows - RW'(1)) : (row_w - RW'(1));
            ncol = col - 2'd1;
        end else begin
            nrow = ((row_w + RW'(1)) == i_rows) ? '0 : (row_w + RW'(1));
            ncol = col + 2'd1;
        end
    end

    assign src       = tail ? i_pos : {nrow[AW-3:0], ncol};
    assign o_rd_addr = src;

    // Encrypt source beyond the message: marker then zeros
    always_comb begin
        if (CW'(src) < i_count) begin
            plain = i_rd_data;
        end else if (CW'(src) == i_count) begin
            plain = bsx_pkg::pad_marker(i_count[2:0]);
        end else begin
            plain = 8'h00;
        end
    end

    // Key applies at the output position on encrypt, at the stored position on decrypt
    always_comb begin
        if (i_decrypt) begin
            o_value = i_rd_data ^ bsx_pkg::key_byte(i_key, src[3:0]);
        end else begin
            o_value = plain ^ bsx_pkg::key_byte(i_key, i_pos[3:0]);
        end
    end

endmodule

`default_nettype wire

// ----- sv/byte_shuffle_xor_cipher.sv -----
// Byte shuffle XOR cipher: message buffer, sequencer and output register
// Flow: bytes load 1 per cycle while not busy; after the last byte an evaluate state, then a
//   read and an output state per result byte, and on decrypt first a read and a check state per
//   byte scanned back to the marker; each result is registered and never stalls (one read port).
// Overflow and short errors give one result from the evaluate state; padding and
//   all-zero errors follow the scan. Synchronous active-low reset clears keys and sequencer.
`timescale 1ns / 1ps
`default_nettype none

`include "byte_shuffle_xor_cipher_macros.svh"

module byte_shuffle_xor_cipher #(
    parameter int BUFFER_BYTES = bsx_pkg::BUFFER_BYTES_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // command channel
    input  wire logic        start,
    output logic             busy,
    input  wire logic        i_mode,
    input  wire logic [7:0]  i_data_byte,
    input  wire logic        i_msg_last,
    // configuration writes
    input  wire logic        i_cfg_wr_en,
    input  wire logic        i_cfg_addr,
    input  wire logic [63:0] i_cfg_data,
    // results
    output logic             o_out_valid,
    output logic      [7:0]  o_out_byte,
    output logic             o_out_last,
    output logic      [1:0]  o_status,
    output logic      [6:0]  o_result_length
);

    localparam int AW = $clog2(BUFFER_BYTES);
    localparam int CW = $clog2(BUFFER_BYTES + 1);
    localparam int RW = CW - 2;

    bsx_pkg::t_state r_state, n_state;
    logic [63:0]     r_key_low, r_key_high;
    logic [CW-1:0]   r_count, n_count;
    logic            r_ovf, n_ovf;
    logic            r_mode, n_mode;
    logic [AW-1:0]   r_pos, n_pos;
    logic [RW-1:0]   r_rows, n_rows;
    logic [CW-1:0]   r_len, n_len;

    logic            r_out_valid, n_out_valid;
    logic [7:0]      r_out_byte, n_out_byte;
    logic            r_out_last, n_out_last;
    logic [1:0]      r_status, n_status;
    logic [CW-1:0]   r_result_length, n_result_length;

    logic            wr_en;
    logic [AW-1:0]   rd_addr;
    logic [7:0]      rd_data;
    logic [7:0]      xf_value;
    logic [CW:0]     enc_total;
    logic [CW-1:0]   zcnt;
    logic [CW-1:0]   dec_len;
    logic            pos_last;
    logic            err_fire;
    logic [1:0]      err_code;
    logic            finish;

    assign busy = (r_state != bsx_pkg::S_IDLE);

    // Store takes bytes while there is room
    assign wr_en = start && !busy && (r_count < CW'(BUFFER_BYTES));

    bsx_store #(
        .DEPTH (BUFFER_BYTES)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (AW'(r_count)),
        .i_wr_data (i_data_byte),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    bsx_xform #(
        .BUFFER_BYTES (BUFFER_BYTES)
    ) u_xform (
        .i_decrypt (r_mode),
        .i_pos     (r_pos),
        .i_rows    (r_rows),
        .i_count   (r_count),
        .i_key     ({r_key_high, r_key_low}),
        .i_rd_data (rd_data),
        .o_rd_addr (rd_addr),
        .o_value   (xf_value)
    );

    // Padded encrypt length, trailing-zero count and decrypt result length
    assign enc_total = {1'b0, r_count}
                     + (CW+1)'(bsx_pkg::pad_marker(r_count[2:0])) + (CW+1)'(1);
    assign zcnt      = r_count - CW'(1) - CW'(r_pos);
    assign dec_len   = (zcnt == '0) ? r_count : CW'(r_pos);
    assign pos_last  = ((CW'(r_pos) + CW'(1)) == r_len);

    // Sequencer: next state and outputs
    always_comb begin
        n_state         = r_state;
        n_count         = r_count;
        n_ovf           = r_ovf;
        n_mode          = r_mode;
        n_pos           = r_pos;
        n_rows          = r_rows;
        n_len           = r_len;
        n_out_valid     = 1'b0;
        n_out_byte      = r_out_byte;
        n_out_last      = r_out_last;
        n_status        = r_status;
        n_result_length = r_result_length;
        err_fire        = 1'b0;
        err_code        = bsx_pkg::ST_OK;
        finish          = 1'b0;

        unique case (r_state)
            bsx_pkg::S_IDLE: begin
                if (start) begin
                    if ((r_count == '0) && !r_ovf) begin
                        n_mode = i_mode;
                    end
                    if (r_count < CW'(BUFFER_BYTES)) begin
                        n_count = r_count + CW'(1);
                    end else begin
                        n_ovf = 1'b1;
                    end
                    if (i_msg_last) begin
                        n_state = bsx_pkg::S_EVAL;
                    end
                end
            end
            bsx_pkg::S_EVAL: begin
                if (r_ovf) begin
                    err_fire = 1'b1;
                    err_code = bsx_pkg::ST_OVERFLOW;
                    finish   = 1'b1;
                end else if (!r_mode) begin
                    if (enc_total > (CW+1)'(BUFFER_BYTES)) begin
                        err_fire = 1'b1;
                        err_code = bsx_pkg::ST_OVERFLOW;
                        finish   = 1'b1;
                    end else begin
                        n_rows  = RW'(enc_total >> 2);
                        n_len   = CW'(enc_total);
                        n_pos   = '0;
                        n_state = bsx_pkg::S_ENC_RD;
                    end
                end else if (r_count < CW'(4)) begin
                    err_fire = 1'b1;
                    err_code = bsx_pkg::ST_SHORT;
                    finish   = 1'b1;
                end else begin
                    n_rows  = RW'(r_count >> 2);
                    n_pos   = AW'(r_count - CW'(1));
                    n_state = bsx_pkg::S_SCAN_RD;
                end
            end
            bsx_pkg::S_ENC_RD: begin
                n_state = bsx_pkg::S_ENC_OUT;
            end
            bsx_pkg::S_DEC_RD: begin
                n_state = bsx_pkg::S_DEC_OUT;
            end
            bsx_pkg::S_ENC_OUT, bsx_pkg::S_DEC_OUT: begin
                n_out_valid     = 1'b1;
                n_out_byte      = xf_value;
                n_out_last      = pos_last;
                n_status        = bsx_pkg::ST_OK;
                n_result_length = r_len;
                if (pos_last) begin
                    finish = 1'b1;
                end else begin
                    n_pos   = r_pos + AW'(1);
                    n_state = (r_state == bsx_pkg::S_ENC_OUT) ? bsx_pkg::S_ENC_RD
                                                               : bsx_pkg::S_DEC_RD;
                end
            end
            bsx_pkg::S_SCAN_RD: begin
                n_state = bsx_pkg::S_SCAN_CHK;
            end
            bsx_pkg::S_SCAN_CHK: begin
                // Walk back over trailing zeros, then check the marker
                if (xf_value != 8'h00) begin
                    if ((zcnt != '0) && (xf_value != 8'(zcnt))) begin
                        err_fire = 1'b1;
                        err_code = bsx_pkg::ST_BAD_PAD;
                        finish   = 1'b1;
                    end else if (dec_len == '0) begin
                        finish = 1'b1;
                    end else begin
                        n_len   = dec_len;
                        n_pos   = '0;
                        n_state = bsx_pkg::S_DEC_RD;
                    end
                end else if (r_pos == '0) begin
                    err_fire = 1'b1;
                    err_code = bsx_pkg::ST_SHORT;
                    finish   = 1'b1;
                end else begin
                    n_pos   = r_pos - AW'(1);
                    n_state = bsx_pkg::S_SCAN_RD;
                end
            end
        endcase

        // Single flagged result on any error
        if (err_fire) begin
            n_out_valid     = 1'b1;
            n_out_byte      = 8'h00;
            n_out_last      = 1'b1;
            n_status        = err_code;
            n_result_length = '0;
        end

        // End of message: ready for the next one
        if (finish) begin
            n_count = '0;
            n_ovf   = 1'b0;
            n_state = bsx_pkg::S_IDLE;
        end
    end

    // Control registers and key registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= bsx_pkg::S_IDLE;
            r_count     <= '0;
            r_ovf       <= 1'b0;
            r_mode      <= 1'b0;
            r_out_valid <= 1'b0;
            r_key_low   <= '0;
            r_key_high  <= '0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_ovf       <= n_ovf;
            r_mode      <= n_mode;
            r_out_valid <= n_out_valid;
            if (i_cfg_wr_en) begin
                unique case (i_cfg_addr)
                    bsx_pkg::REG_KEY_LOW:  r_key_low  <= i_cfg_data;
                    bsx_pkg::REG_KEY_HIGH: r_key_high <= i_cfg_data;
                endcase
            end
        end
    end

    // Datapath and result payload registers
    always_ff @(posedge i_clk) begin
        r_pos           <= n_pos;
        r_rows          <= n_rows;
        r_len           <= n_len;
        r_out_byte      <= n_out_byte;
        r_out_last      <= n_out_last;
        r_status        <= n_status;
        r_result_length <= n_result_length;
    end

    assign o_out_valid     = r_out_valid;
    assign o_out_byte      = r_out_byte;
    assign o_out_last      = r_out_last;
    assign o_status        = r_status;
    assign o_result_length = 7'(r_result_length);

    // Checks
    `BSX_CHECK(a_err_shape, o_out_valid && (o_status != bsx_pkg::ST_OK), o_out_last && (o_out_byte == 8'h00) && (o_result_length == 7'd0), "error result not zero and last")
    `BSX_CHECK(a_more_busy, o_out_valid && !o_out_last, busy, "idle while results remain")
    `BSX_CHECK(a_count_bound, 1'b1, r_count <= CW'(BUFFER_BYTES), "byte count past buffer depth")
    `BSX_CHECK_NEXT(a_last_busy, start && !busy && i_msg_last, busy, "not busy after final byte")

endmodule

`default_nettype wire
